// ----- design/clps_pkg.sv -----
// shared types, constants and pin maps for the charlieplexed led scanner
package clps_pkg;

  localparam int LED_COUNT = 96;
  localparam int PIN_COUNT = 11;
  localparam int ROW_SLOTS = 10;

  typedef logic [PIN_COUNT-1:0] pins_t;
  typedef logic [3:0]           row_t;
  typedef logic [3:0]           pin_t;
  typedef logic [2:0]           pend_t;
  typedef logic [1:0]           level_t;
  typedef logic [6:0]           index_t;
  typedef logic [31:0]          word_t;
  typedef logic [1:0]           cfg_index_t;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_TICK  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    CFG_PERIOD_FULL = 2'd0,
    CFG_LEVEL_ONE   = 2'd1,
    CFG_LEVEL_TWO   = 2'd2
  } cfg_reg_t;

  localparam row_t   ROW_NONE = 4'd15;
  localparam pend_t  NO_LEVEL = 3'd4;
  localparam level_t LVL_OFF  = 2'd0;
  localparam level_t LVL_DIM  = 2'd1;
  localparam level_t LVL_MED  = 2'd2;
  localparam level_t LVL_FULL = 2'd3;

  // low side pin of each led
  localparam pin_t LOW_PIN [LED_COUNT] = '{
    3, 7, 4, 7, 4, 3, 8, 7, 8, 3, 8, 4,
    0, 7, 0, 3, 0, 4, 0, 8, 6, 7, 6, 3,
    6, 4, 6, 8, 6, 0, 5, 7, 5, 3, 5, 4,
    5, 8, 5, 0, 5, 6, 1, 7, 1, 3, 1, 4,
    1, 8, 1, 0, 1, 6, 1, 5, 2, 7, 2, 3,
    2, 4, 2, 8, 2, 0, 2, 6, 2, 5, 2, 1,
    10, 7, 10, 3, 10, 4, 10, 8, 10, 0, 10, 6,
    10, 5, 10, 1, 10, 2, 9, 7, 9, 3, 9, 4
  };

  // per row: led number, or bit 7 set with an unused pin to release
  localparam logic [7:0] ROW_MAP [PIN_COUNT][ROW_SLOTS] = '{
    '{8'd50, 8'd64, 8'd15, 8'd17, 8'd38, 8'd28, 8'd13, 8'd19, 8'd80, 8'h89},
    '{8'd51, 8'd70, 8'd45, 8'd47, 8'd55, 8'd53, 8'd43, 8'd49, 8'd86, 8'h89},
    '{8'd65, 8'd71, 8'd59, 8'd61, 8'd69, 8'd67, 8'd57, 8'd63, 8'd88, 8'h89},
    '{8'd14, 8'd44, 8'd58, 8'd4,  8'd32, 8'd22, 8'd1,  8'd8,  8'd92, 8'd74},
    '{8'd16, 8'd46, 8'd60, 8'd5,  8'd34, 8'd24, 8'd3,  8'd10, 8'd94, 8'd76},
    '{8'd39, 8'd54, 8'd68, 8'd33, 8'd35, 8'd41, 8'd31, 8'd37, 8'd84, 8'h89},
    '{8'd29, 8'd52, 8'd66, 8'd23, 8'd25, 8'd40, 8'd21, 8'd27, 8'd82, 8'h89},
    '{8'd12, 8'd42, 8'd56, 8'd0,  8'd2,  8'd30, 8'd20, 8'd6,  8'd90, 8'd72},
    '{8'd18, 8'd48, 8'd62, 8'd9,  8'd11, 8'd36, 8'd26, 8'd7,  8'd78, 8'h89},
    '{8'd93, 8'd95, 8'd91, 8'h80, 8'h81, 8'h82, 8'h85, 8'h86, 8'h88, 8'h8A},
    '{8'd81, 8'd87, 8'd89, 8'd75, 8'd77, 8'd85, 8'd83, 8'd73, 8'd79, 8'h89}
  };

  // scan state carried from tick to tick
  typedef struct packed {
    row_t  row;
    pend_t pend;
    word_t frame;
    pins_t drive_en;
    pins_t drive_lvl;
  } scan_state_t;

  typedef struct packed {
    word_t full;
    word_t one;
    word_t two;
  } periods_t;

  function automatic logic slot_is_led(input int r, input int s);
    return !ROW_MAP[r][s][7];
  endfunction

  function automatic pin_t slot_pin(input int r, input int s);
    logic [7:0] e;
    e = ROW_MAP[r][s];
    if (e[7]) return e[3:0];
    return LOW_PIN[e[6:0]];
  endfunction

endpackage

// ----- design/clps_ifs.sv -----
// valid/ready channel interfaces for input words and result words
interface clps_item_if import clps_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   action;
  index_t led_index;
  level_t pixel_level;

  modport source(output valid, action, led_index, pixel_level, input ready);
  modport sink(input valid, action, led_index, pixel_level, output ready);
endinterface

interface clps_result_if import clps_pkg::*; ();
  logic  valid;
  logic  ready;
  pins_t pin_enable;
  pins_t pin_high;
  word_t next_period;
  row_t  active_row_out;
  word_t frame_count;

  modport source(output valid, pin_enable, pin_high, next_period, active_row_out,
                 frame_count, input ready);
  modport sink(input valid, pin_enable, pin_high, next_period, active_row_out,
               frame_count, output ready);
endinterface

// ----- design/clps_tick_logic.sv -----
// next scan state and timer period for one tick
module clps_tick_logic import clps_pkg::*; (
  input  scan_state_t                 cur,
  input  logic [LED_COUNT-1:0][1:0]   levels,
  input  periods_t                    periods,
  output scan_state_t                 nxt,
  output word_t                       period
);

  level_t [ROW_SLOTS-1:0] old_lvl;
  logic   [ROW_SLOTS-1:0] old_led;
  pin_t   [ROW_SLOTS-1:0] old_pin;
  level_t [ROW_SLOTS-1:0] new_lvl;
  logic   [ROW_SLOTS-1:0] new_led;
  pin_t   [ROW_SLOTS-1:0] new_pin;

  logic  rel_active;
  logic  gt1, gt2, gt3;
  pend_t rel_next;
  pins_t rel_mask;
  pins_t en1, lvl1;
  row_t  row_inc, row_new;
  logic  frame_step;
  logic  has1, has2, has3, any_lit;
  pins_t touch_mask, drive_mask;
  pins_t en2, lvl2;
  pend_t adv_pend;

  // row that follows the current one
  assign row_inc    = cur.row + 4'd1;
  assign frame_step = row_inc >= row_t'(PIN_COUNT);
  assign row_new    = frame_step ? 4'd0 : row_inc;

  // gather the ten levels of the current row and of the row that follows
  always_comb begin
    old_lvl = '0;
    old_led = '0;
    old_pin = '0;
    new_lvl = '0;
    new_led = '0;
    new_pin = '0;
    for (int s = 0; s < ROW_SLOTS; s++) begin
      for (int r = 0; r < PIN_COUNT; r++) begin
        if (cur.row == row_t'(r)) begin
          old_led[s] = slot_is_led(r, s);
          old_pin[s] = slot_pin(r, s);
          if (slot_is_led(r, s)) old_lvl[s] = levels[ROW_MAP[r][s][6:0]];
        end
        if (row_new == row_t'(r)) begin
          new_led[s] = slot_is_led(r, s);
          new_pin[s] = slot_pin(r, s);
          if (slot_is_led(r, s)) new_lvl[s] = levels[ROW_MAP[r][s][6:0]];
        end
      end
    end
  end

  // release slot: drop leds whose level ran out
  always_comb begin
    rel_active = (cur.pend != 3'd0) && (cur.row < row_t'(PIN_COUNT));
    gt1 = 1'b0;
    gt2 = 1'b0;
    gt3 = 1'b0;
    rel_mask = '0;
    for (int s = 0; s < ROW_SLOTS; s++) begin
      if (old_led[s]) begin
        if ({1'b0, old_lvl[s]} == cur.pend) rel_mask |= pins_t'(1'b1) << old_pin[s];
        if (old_lvl[s] == LVL_DIM  && cur.pend < 3'd1) gt1 = 1'b1;
        if (old_lvl[s] == LVL_MED  && cur.pend < 3'd2) gt2 = 1'b1;
        if (old_lvl[s] == LVL_FULL && cur.pend < 3'd3) gt3 = 1'b1;
      end
    end
    if (gt1)      rel_next = 3'd1;
    else if (gt2) rel_next = 3'd2;
    else if (gt3) rel_next = 3'd3;
    else          rel_next = NO_LEVEL;
    if (rel_next == NO_LEVEL) rel_mask |= pins_t'(1'b1) << cur.row;
    if (rel_active) begin
      en1  = cur.drive_en & ~rel_mask;
      lvl1 = cur.drive_lvl & ~rel_mask;
    end else begin
      en1  = cur.drive_en;
      lvl1 = cur.drive_lvl;
    end
  end

  // row advance
  always_comb begin
    has1 = 1'b0;
    has2 = 1'b0;
    has3 = 1'b0;
    touch_mask = '0;
    drive_mask = '0;
    for (int s = 0; s < ROW_SLOTS; s++) begin
      touch_mask |= pins_t'(1'b1) << new_pin[s];
      if (new_led[s] && new_lvl[s] != LVL_OFF) drive_mask |= pins_t'(1'b1) << new_pin[s];
      if (new_led[s] && new_lvl[s] == LVL_DIM)  has1 = 1'b1;
      if (new_led[s] && new_lvl[s] == LVL_MED)  has2 = 1'b1;
      if (new_led[s] && new_lvl[s] == LVL_FULL) has3 = 1'b1;
    end
    any_lit = has1 | has2 | has3;
    en2  = (en1 & ~touch_mask) | drive_mask;
    lvl2 = lvl1 & ~touch_mask;
    if (any_lit) begin
      en2  = en2 | (pins_t'(1'b1) << row_new);
      lvl2 = lvl2 | (pins_t'(1'b1) << row_new);
    end
    if (has1)      adv_pend = 3'd1;
    else if (has2) adv_pend = 3'd2;
    else if (has3) adv_pend = 3'd3;
    else           adv_pend = 3'd0;
  end

  // pick the outcome and the period
  always_comb begin
    nxt = cur;
    if (rel_active && cur.pend < 3'd3) begin
      nxt.pend      = rel_next;
      nxt.drive_en  = en1;
      nxt.drive_lvl = lvl1;
      if (cur.pend == 3'd1 && rel_next == 3'd2) period = periods.two - periods.one;
      else if (cur.pend == 3'd1)                period = periods.full - periods.one;
      else                                      period = periods.full - periods.two;
    end else begin
      nxt.row       = row_new;
      nxt.pend      = adv_pend;
      nxt.frame     = frame_step ? cur.frame + 32'd1 : cur.frame;
      nxt.drive_en  = en2;
      nxt.drive_lvl = lvl2;
      if (adv_pend == 3'd1)      period = periods.one;
      else if (adv_pend == 3'd2) period = periods.two;
      else                       period = periods.full;
    end
  end

endmodule

// ----- design/charlieplex_led_scan_grayscale_unit.sv -----
// top level of the charlieplexed led matrix scanner with four-level grayscale
// Scans a 96-led charlieplexed matrix on 11 tristate pins. Input words either
// store a 2-bit brightness for one led (action 0, no result) or report one
// timer expiry (action 1, exactly one result word). A tick either releases the
// leds of the current row whose on-time ran out, or advances to the next row
// and drives its high pin and the low pins of its lit leds. Each result gives
// the pin drive, the timer period to load next, the row being served and the
// frame count. One word is taken every clock cycle, but a tick waits while the
// result register holds a word that is not taken: a word is held in the input
// register and the tick update runs combinationally from there into the result
// register, reading the levels of the row's ten leds from flops. The level store
// is cleared by reset at once. The user must write period registers on the cfg
// port only while no word is in flight; the block itself does not enforce this.
module charlieplex_led_scan_grayscale_unit import clps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  clps_item_if.sink          item_in,
  clps_result_if.source      result_out,
  input  logic               cfg_write_en,
  input  cfg_index_t         cfg_index,
  input  word_t              cfg_data
);

  // input register
  logic   in_valid;
  logic   in_action;
  index_t in_index;
  level_t in_level;

  // result register
  logic  out_valid;
  pins_t out_enable;
  pins_t out_high;
  word_t out_period;
  row_t  out_row;
  word_t out_frame;

  // period registers
  periods_t periods;

  // brightness store, one 2-bit level per led
  logic [LED_COUNT-1:0][1:0] levels;

  scan_state_t scan;
  scan_state_t scan_next;
  word_t       period_next;

  logic stage_go;
  logic is_tick;

  assign is_tick  = (in_action == ACT_TICK);
  // writes never wait; ticks wait only on a full result register
  assign stage_go = in_valid && (!is_tick || !out_valid || result_out.ready);
  assign item_in.ready = !in_valid || stage_go;

  // config writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      periods.full <= 32'd4096;
      periods.one  <= 32'd512;
      periods.two  <= 32'd1024;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_PERIOD_FULL: periods.full <= cfg_data;
        CFG_LEVEL_ONE:   periods.one  <= cfg_data;
        CFG_LEVEL_TWO:   periods.two  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_in.ready) begin
      in_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      in_action <= item_in.action;
      in_index  <= item_in.led_index;
      in_level  <= item_in.pixel_level;
    end
  end

  // level store, out of range indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= '0;
    end else if (stage_go && !is_tick && in_index < index_t'(LED_COUNT)) begin
      levels[in_index] <= in_level;
    end
  end

  clps_tick_logic u_tick (
    .cur     (scan),
    .levels  (levels),
    .periods (periods),
    .nxt     (scan_next),
    .period  (period_next)
  );

  // scan state moves only on ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      scan.row       <= ROW_NONE;
      scan.pend      <= 3'd0;
      scan.frame     <= '0;
      scan.drive_en  <= '0;
      scan.drive_lvl <= '0;
    end else if (stage_go && is_tick) begin
      scan <= scan_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_go && is_tick) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && is_tick) begin
      out_enable <= scan_next.drive_en;
      out_high   <= scan_next.drive_lvl;
      out_period <= period_next;
      out_row    <= scan_next.row;
      out_frame  <= scan_next.frame;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.pin_enable     = out_enable;
  assign result_out.pin_high       = out_high;
  assign result_out.next_period    = out_period;
  assign result_out.active_row_out = out_row;
  assign result_out.frame_count    = out_frame;

endmodule

// ----- design/clps_checker.sv -----
// port-level checks for the led scanner, bound to the top level
module clps_checker import clps_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  out_valid,
  input logic  out_ready,
  input pins_t pin_enable,
  input pins_t pin_high,
  input word_t next_period,
  input row_t  active_row_out,
  input word_t frame_count
);

  // every result follows a tick, so a real row is being served
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> active_row_out < row_t'(PIN_COUNT))
    else $error("result row out of range");

  // a released pin is never marked high
  a_high_enabled: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pin_high & ~pin_enable) == '0)
    else $error("high level on released pin");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pin_enable) && $stable(pin_high)
      && $stable(next_period) && $stable(active_row_out) && $stable(frame_count))
    else $error("stalled result changed");

endmodule

bind charlieplex_led_scan_grayscale_unit clps_checker u_clps_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result_out.valid),
  .out_ready      (result_out.ready),
  .pin_enable     (result_out.pin_enable),
  .pin_high       (result_out.pin_high),
  .next_period    (result_out.next_period),
  .active_row_out (result_out.active_row_out),
  .frame_count    (result_out.frame_count)
);
